/* rtl/bra_pkg.sv */
// Shared types and constants for the bitmap run allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bra_pkg;

  typedef enum logic [1:0] {
    FUNC_TEST  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_SCAN  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_NOFIT   = 2'd1,
    RES_INVALID = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_BIT   = 2'd1,
    SRC_START = 2'd2
  } src_t;

  localparam logic [7:0] BIU_RESET        = 8'd128;
  localparam logic       REG_BYTES_IN_USE = 1'b0;

  typedef struct packed {
    logic load_req;
    logic addr_clr;
    logic addr_inc;
    logic ram_rd;
    logic ram_wr;
    logic use_index;
    logic wr_zero;
    logic scan_init;
    logic scan_issue;
    logic scan_eval;
    logic res_set;
    res_t res_code;
    src_t res_src;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  index_ok;
    logic  len_zero;
    logic  live_zero;
    logic  sweep_last;
    logic  init_last;
    logic  scan_hit;
    logic  scan_miss;
  } sts_t;

endpackage

/* rtl/bra_ram.sv */
// Generic single-port RAM with a registered read.
// Stands alone; used by the allocator datapath for the mark bytes.
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             re,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/bra_dp.sv */
// Datapath of the bitmap run allocator: request registers, mark RAM, address
// counter, byte-wide run search and result registers. Uses bra_pkg and bra_ram.
module bra_dp import bra_pkg::*; #(
  parameter int MAP_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  bytes_in_use,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_bit_index,
  input  logic        in_bit_value,
  input  logic [10:0] in_run_length,
  output logic [1:0]  status,
  output logic [9:0]  run_start,
  output logic        bit_read
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int BW = $clog2(MAP_BYTES + 1);
  localparam int XW = (BW > 8) ? BW : 8;
  localparam int SW = AW + 3;
  localparam int OW = (SW > 10) ? SW : 10;
  localparam int IW = (AW > 7) ? AW : 7;

  func_t       req_func;
  logic [9:0]  req_index;
  logic        req_value;
  logic [10:0] req_len;

  logic [AW-1:0] addr;
  logic [AW-1:0] eval_addr;
  logic          eval_vld;
  logic          issue_done;
  logic [10:0]   count;
  logic [SW-1:0] run_begin;

  res_t        res_status;
  logic [9:0]  res_start;
  logic        res_bit;

  logic [XW-1:0] live_bytes;
  logic [IW-1:0] req_byte;
  logic [AW-1:0] idx_addr;
  logic          scan_rd;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [7:0]    bit_mask;
  logic          sel_bit;

  logic [10:0]   c_count;
  logic [SW-1:0] c_begin;
  logic          c_found;
  logic [SW-1:0] c_start;
  logic [SW-1:0] c_pos;
  logic [OW-1:0] start_x;

  assign live_bytes = (XW'(bytes_in_use) > XW'(MAP_BYTES)) ? XW'(MAP_BYTES)
                                                          : XW'(bytes_in_use);
  assign req_byte   = IW'(req_index[9:3]);
  assign idx_addr   = req_byte[AW-1:0];
  assign bit_mask   = 8'd1 << req_index[2:0];
  assign sel_bit    = ram_rdata[req_index[2:0]];

  assign scan_rd   = cmd.scan_issue && !issue_done;
  assign ram_re    = cmd.ram_rd || scan_rd;
  assign ram_addr  = cmd.use_index ? idx_addr : addr;
  assign ram_wdata = cmd.wr_zero ? 8'd0 :
                     (req_value ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));

  bra_ram #(
    .WIDTH(8),
    .DEPTH(MAP_BYTES)
  ) u_ram (
    .clk  (clk),
    .re   (ram_re),
    .we   (cmd.ram_wr),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    c_count = count;
    c_begin = run_begin;
    c_found = 1'b0;
    c_start = '0;
    c_pos   = '0;
    for (int k = 0; k < 8; k++) begin
      c_pos = {eval_addr, 3'(k)};
      if (!c_found) begin
        if (ram_rdata[k]) begin
          c_count = '0;
          c_begin = c_pos + SW'(1);
        end else begin
          c_count = c_count + 11'd1;
          if (c_count == req_len) begin
            c_found = 1'b1;
            c_start = c_begin;
          end
        end
      end
    end
  end

  assign start_x = OW'(c_start);

  always_comb begin
    sts.func       = req_func;
    sts.index_ok   = XW'(req_index[9:3]) < live_bytes;
    sts.len_zero   = req_len == 11'd0;
    sts.live_zero  = live_bytes == '0;
    sts.sweep_last = (XW'(addr) + XW'(1)) == live_bytes;
    sts.init_last  = addr == AW'(MAP_BYTES - 1);
    sts.scan_hit   = eval_vld && c_found;
    sts.scan_miss  = eval_vld && !c_found && ((XW'(eval_addr) + XW'(1)) == live_bytes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      eval_vld   <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      if (cmd.addr_clr) begin
        addr <= '0;
      end else if (cmd.addr_inc || scan_rd) begin
        addr <= addr + AW'(1);
      end
      eval_vld <= scan_rd;
      if (cmd.scan_init) begin
        issue_done <= 1'b0;
      end else if (scan_rd && sts.sweep_last) begin
        issue_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_addr <= addr;
    if (cmd.load_req) begin
      req_func  <= func_t'(in_func);
      req_index <= in_bit_index;
      req_value <= in_bit_value;
      req_len   <= in_run_length;
    end
    if (cmd.scan_init) begin
      count     <= '0;
      run_begin <= '0;
    end else if (cmd.scan_eval && eval_vld) begin
      count     <= c_count;
      run_begin <= c_begin;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_bit    <= (cmd.res_src == SRC_BIT) ? sel_bit : 1'b0;
      res_start  <= (cmd.res_src == SRC_START) ? start_x[9:0] : 10'd0;
    end
    if (cmd.out_load) begin
      status    <= res_status;
      run_start <= res_start;
      bit_read  <= res_bit;
    end
  end

endmodule

/* rtl/bra_ctrl.sv */
// Controller state machine of the bitmap run allocator: sequences the reset
// sweep, each request and the output handshake. Uses bra_pkg.
module bra_ctrl import bra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_ACCESS,
    ST_WIPE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign s_tready = state == ST_IDLE;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        cmd.ram_wr   = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (sts.init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.addr_clr = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.func)
          FUNC_TEST, FUNC_WRITE: begin
            if (!sts.index_ok) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = RES_INVALID;
              state_next   = ST_DONE;
            end else begin
              cmd.ram_rd    = 1'b1;
              cmd.use_index = 1'b1;
              state_next    = ST_ACCESS;
            end
          end
          FUNC_SCAN: begin
            if (sts.len_zero) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = RES_INVALID;
              state_next   = ST_DONE;
            end else if (sts.live_zero) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = RES_NOFIT;
              state_next   = ST_DONE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = ST_SCAN;
            end
          end
          default: begin
            if (sts.live_zero) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = RES_OK;
              state_next   = ST_DONE;
            end else begin
              state_next = ST_WIPE;
            end
          end
        endcase
      end
      ST_ACCESS: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = RES_OK;
        if (sts.func == FUNC_TEST) begin
          cmd.res_src = SRC_BIT;
        end else begin
          cmd.ram_wr    = 1'b1;
          cmd.use_index = 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_WIPE: begin
        cmd.ram_wr   = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (sts.sweep_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = RES_OK;
          state_next   = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.scan_eval  = 1'b1;
        if (sts.scan_hit) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = RES_OK;
          cmd.res_src  = SRC_START;
          state_next   = ST_DONE;
        end else if (sts.scan_miss) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = RES_NOFIT;
          state_next   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an unread result");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while one is in progress");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ram_wr && cmd.scan_issue))
    else $error("mark write during a scan");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result valid without a result load");
`endif

endmodule

/* rtl/bitmap_run_allocator_top.sv */
// Top level of the bitmap run allocator: stream ports, APB register and the
// controller and datapath. Depends on bra_pkg, bra_ctrl and bra_dp.
//
// First-fit allocator over MAP_BYTES bytes of allocation marks held in one
// single-port RAM. Requests are handled one at a time, and a scan or a clear-all
// walks the bytes in use one RAM access per cycle (a scan stops early when it
// finds its run). After reset the block zeroes the whole RAM, one byte per
// cycle, before it takes its first request; register writes are taken during
// that time. A finished result sits in an output register, and the next
// request is taken while it waits.
module bitmap_run_allocator_top import bra_pkg::*; #(
  parameter int MAP_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] func, [11:2] bit_index, [12] bit_value, [23:13] run_length
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [11:2] run_start, [12] bit_read, [15:13] zero
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] bytes_in_use;
  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] status;
  logic [9:0] run_start;
  logic       bit_read;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BYTES_IN_USE) ? {24'd0, bytes_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= BIU_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BYTES_IN_USE)) begin
      bytes_in_use <= pwdata[7:0];
    end
  end

  bra_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bra_dp #(
    .MAP_BYTES(MAP_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .bytes_in_use (bytes_in_use),
    .in_func      (s_tdata[1:0]),
    .in_bit_index (s_tdata[11:2]),
    .in_bit_value (s_tdata[12]),
    .in_run_length(s_tdata[23:13]),
    .status       (status),
    .run_start    (run_start),
    .bit_read     (bit_read)
  );

  assign m_tdata = {3'd0, bit_read, run_start, status};

endmodule
